[design/char_lcd_nibble_write_sequencer_top_assert.svh]
// Assertion macros used by the LCD sequencer checker.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define LCD4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define LCD4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lcd4_pkg.sv]
// Package: types, codes and tables of the LCD nibble write sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lcd4_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 8;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 2;
    localparam int NIB_W   = 4;
    localparam int HOLD_W  = 12;
    localparam int IDX_W   = 3;

    // Operation codes carried by a request beat
    typedef enum logic [OP_W-1:0] {
        OP_CMD    = 3'd0,
        OP_DATA   = 3'd1,
        OP_CURSOR = 3'd2,
        OP_INIT   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Which hold time an event carries
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_PULSE,
        HOLD_INIT
    } hold_sel_t;

    localparam logic [HOLD_W-1:0]  INIT_GAP_US = 12'd5;
    localparam logic [VALUE_W-1:0] CMD_CLEAR   = 8'h01;
    localparam logic               RW_WRITE    = 1'b0;

    // Event positions within one byte
    localparam logic [IDX_W-1:0] EVT_HI_STROBE = 3'd1;
    localparam logic [IDX_W-1:0] EVT_LO_FIRST  = 3'd3;
    localparam logic [IDX_W-1:0] EVT_LO_STROBE = 3'd4;
    localparam logic [IDX_W-1:0] EVT_LAST      = 3'd5;
    localparam logic [IDX_W-1:0] INIT_LAST     = 3'd5;

    // Control from the sequencer to the byte unit
    typedef struct packed {
        logic                 load;
        logic [OP_W-1:0]      op;
        logic [IDX_W-1:0]     init_idx;
    } byte_ctl_t;

    // One pin event handed from the sequencer to the output stage
    typedef struct packed {
        logic                 load;
        logic                 use_held;
        logic [NIB_W-1:0]     nibble;
        logic                 rs;
        logic                 en;
        hold_sel_t            hold;
        logic                 last;
    } evt_t;

    function automatic logic [VALUE_W-1:0] row_base(input logic [ROW_W-1:0] row);
        logic [VALUE_W-1:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            2'd3:    base = 8'hD4;
            default: base = 8'h80;
        endcase
        return base;
    endfunction

    function automatic logic [VALUE_W-1:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[design/lcd4_req_if.sv]
// Interface: request channel carrying one display operation per beat.
`timescale 1ns / 1ps
`default_nettype none
interface lcd4_req_if import lcd4_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;

    modport source (output valid, output operation, output value, output column,
                    output row, input ready);
    modport sink   (input valid, input operation, input value, input column,
                    input row, output ready);
endinterface
`default_nettype wire

[design/lcd4_pin_if.sv]
// Interface: pin event channel, one display pin state per beat.
`timescale 1ns / 1ps
`default_nettype none
interface lcd4_pin_if import lcd4_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NIB_W-1:0]  nibble;
    logic              reg_select;
    logic              read_write;
    logic              enable;
    logic [HOLD_W-1:0] hold_us;
    logic              last;

    modport source (output valid, output nibble, output reg_select, output read_write,
                    output enable, output hold_us, output last, input ready);
    modport sink   (input valid, input nibble, input reg_select, input read_write,
                    input enable, input hold_us, input last, output ready);
endinterface
`default_nettype wire

[design/lcd4_byte_unit.sv]
// Shared byte unit: one adder forms every byte that goes out to the display.
`timescale 1ns / 1ps
`default_nettype none
module lcd4_byte_unit import lcd4_pkg::*; (
    input  wire logic               clk,
    input  wire byte_ctl_t          ctl,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [COL_W-1:0]   column,
    input  wire logic [ROW_W-1:0]   row,
    output logic [VALUE_W-1:0]      byte_val
);

    logic [VALUE_W-1:0] byte_reg;
    logic [VALUE_W-1:0] byte_next;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] addend;

    // Pick base and addend; only set cursor adds a nonzero column
    always_comb
    begin
        base   = value;
        addend = '0;
        case (ctl.op)
            OP_CURSOR:
            begin
                base   = row_base(row);
                addend = {{(VALUE_W-COL_W){1'b0}}, column};
            end
            OP_INIT:  base = init_byte(ctl.init_idx);
            OP_CLEAR: base = CMD_CLEAR;
            default:  base = value;
        endcase
        byte_next = base + addend;
    end

    // Hold the byte for the six events that carry it
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_val = byte_reg;

endmodule
`default_nettype wire

[design/lcd4_seq.sv]
// Sequencer: walks bytes and the six events of each byte for one operation.
`timescale 1ns / 1ps
`default_nettype none
module lcd4_seq import lcd4_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [OP_W-1:0]    op_in,
    input  wire logic               slot_free,
    input  wire logic [VALUE_W-1:0] byte_val,
    output logic                    idle,
    output byte_ctl_t               bctl,
    output evt_t                    evt
);

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [IDX_W-1:0] evt_idx_reg, evt_idx_next;
    logic [IDX_W-1:0] init_idx_reg, init_idx_next;
    hold_sel_t        gap;

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_CMD;
            evt_idx_reg  <= '0;
            init_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            evt_idx_reg  <= evt_idx_next;
            init_idx_reg <= init_idx_next;
        end
    end

    // Trailing gap after the low nibble depends on the operation
    always_comb
    begin
        case (op_reg)
            OP_CURSOR, OP_CLEAR: gap = HOLD_PULSE;
            OP_INIT:             gap = HOLD_INIT;
            default:             gap = HOLD_NONE;
        endcase
    end

    // Next state and event formation
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        evt_idx_next  = evt_idx_reg;
        init_idx_next = init_idx_reg;
        idle          = 1'b0;
        bctl.load     = 1'b0;
        bctl.op       = op_reg;
        bctl.init_idx = init_idx_reg;
        evt           = '0;
        evt.hold      = HOLD_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                // Drop unused operation codes without any event
                if (start && (op_in <= OP_CLEAR))
                begin
                    op_next       = op_in;
                    init_idx_next = '0;
                    state_next    = (op_in == OP_INIT) ? ST_LEAD : ST_LOAD;
                end
            end

            ST_LEAD:
            begin
                if (slot_free)
                begin
                    evt.load     = 1'b1;
                    evt.use_held = 1'b1;
                    evt.hold     = HOLD_INIT;
                    state_next   = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                bctl.load    = 1'b1;
                evt_idx_next = '0;
                state_next   = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    evt.load   = 1'b1;
                    evt.rs     = (op_reg == OP_DATA);
                    evt.nibble = (evt_idx_reg < EVT_LO_FIRST) ? byte_val[7:4] : byte_val[3:0];
                    evt.en     = (evt_idx_reg == EVT_HI_STROBE) ||
                                 (evt_idx_reg == EVT_LO_STROBE);
                    if (evt_idx_reg == EVT_LAST)
                    begin
                        evt.hold = gap;
                    end
                    else if ((evt_idx_reg == '0) || (evt_idx_reg == EVT_LO_FIRST))
                    begin
                        evt.hold = HOLD_NONE;
                    end
                    else
                    begin
                        evt.hold = HOLD_PULSE;
                    end

                    if (evt_idx_reg == EVT_LAST)
                    begin
                        if ((op_reg == OP_INIT) && (init_idx_reg != INIT_LAST))
                        begin
                            init_idx_next = init_idx_reg + 1'b1;
                            state_next    = ST_LOAD;
                        end
                        else
                        begin
                            evt.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        evt_idx_next = evt_idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/char_lcd_nibble_write_sequencer_top.sv]
// Top level: 4-bit character LCD write sequencer.
//
// Usage:
//   req  - one display operation per beat: command byte, data byte, set
//          cursor (row base plus column), init sequence or clear screen.
//          Unused operation codes are taken and dropped with no event.
//   pins - one pin state per beat: nibble, register select, read/write,
//          enable and the hold time in microseconds; last marks the final
//          event of an operation.
// A byte becomes six events (high nibble, then low nibble, each set up,
// strobed and released). The sequencer forms one event per cycle while
// the pins channel has room, and a byte unit builds each byte in the
// cycle before its six events. A request beat passes through the load
// state and the byte register before its first event enters the output
// register; init sends one leading event first, then six bytes. req.ready
// is high only between operations; the last event may still wait in the
// output register while the next request is taken.
// Reset clears the sequencer, the output valid and the held nibble and
// register select. A stalled pins channel holds its beat and holds the
// sequencer at its next event until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_nibble_write_sequencer_top import lcd4_pkg::*; #(
    parameter int PULSE_WAIT_US = 3000
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lcd4_req_if.sink      req,
    lcd4_pin_if.source    pins
);

    logic               accept;
    logic               idle;
    logic               slot_free;
    byte_ctl_t          bctl;
    evt_t               evt;
    logic [VALUE_W-1:0] byte_val;

    logic [VALUE_W-1:0] value_reg;
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;

    logic               valid_reg, valid_next;
    logic [NIB_W-1:0]   nibble_reg, nibble_next;
    logic               select_reg, select_next;
    logic               enable_reg;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic               last_reg;
    logic [NIB_W-1:0]   held_nibble_reg;
    logic               held_select_reg;

    assign accept    = req.valid && req.ready;
    assign req.ready = idle;
    assign slot_free = !valid_reg || pins.ready;

    // Capture the operand fields of an accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= req.value;
            column_reg <= req.column;
            row_reg    <= req.row;
        end
    end

    lcd4_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .op_in     (req.operation),
        .slot_free (slot_free),
        .byte_val  (byte_val),
        .idle      (idle),
        .bctl      (bctl),
        .evt       (evt)
    );

    lcd4_byte_unit u_byte (
        .clk      (clk),
        .ctl      (bctl),
        .value    (value_reg),
        .column   (column_reg),
        .row      (row_reg),
        .byte_val (byte_val)
    );

    // Resolve the event payload: held pins for the init lead event, hold code to time
    always_comb
    begin
        nibble_next = evt.use_held ? held_nibble_reg : evt.nibble;
        select_next = evt.use_held ? held_select_reg : evt.rs;
        case (evt.hold)
            HOLD_PULSE: hold_next = HOLD_W'(PULSE_WAIT_US);
            HOLD_INIT:  hold_next = INIT_GAP_US;
            default:    hold_next = '0;
        endcase
        valid_next = evt.load ? 1'b1 : (pins.ready ? 1'b0 : valid_reg);
    end

    // Output register valid and held pin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            held_nibble_reg <= '0;
            held_select_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (evt.load)
            begin
                held_nibble_reg <= nibble_next;
                held_select_reg <= select_next;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (evt.load)
        begin
            nibble_reg <= nibble_next;
            select_reg <= select_next;
            enable_reg <= evt.en;
            hold_reg   <= hold_next;
            last_reg   <= evt.last;
        end
    end

    assign pins.valid      = valid_reg;
    assign pins.nibble     = nibble_reg;
    assign pins.reg_select = select_reg;
    assign pins.read_write = RW_WRITE;
    assign pins.enable     = enable_reg;
    assign pins.hold_us    = hold_reg;
    assign pins.last       = last_reg;

endmodule
`default_nettype wire

[design/lcd4_checker.sv]
// Checker: port-level assertions on the LCD sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_nibble_write_sequencer_top_assert.svh"
module lcd4_checker import lcd4_pkg::*; #(
    parameter int PULSE_WAIT_US = 3000
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire logic [OP_W-1:0]   req_operation,
    input  wire logic              pins_valid,
    input  wire logic              pins_ready,
    input  wire logic [NIB_W-1:0]  pins_nibble,
    input  wire logic              pins_read_write,
    input  wire logic              pins_enable,
    input  wire logic [HOLD_W-1:0] pins_hold_us
);

    // A real operation keeps the request side closed on the next cycle
    `LCD4_ASSERT_NEXT(a_busy_after_op, req_valid && req_ready && (req_operation <= OP_CLEAR), !req_ready, "request taken while an operation is in progress")

    // The bus is only ever written
    `LCD4_ASSERT_NOW(a_write_only, pins_valid, pins_read_write == RW_WRITE, "read/write line not in write")

    // Every enable strobe lasts the full pulse time
    `LCD4_ASSERT_NOW(a_strobe_hold, pins_valid && pins_enable, pins_hold_us == HOLD_W'(PULSE_WAIT_US), "enable strobe with wrong hold time")

    // A stalled event beat holds its pin state
    `LCD4_ASSERT_NEXT(a_stall_hold, pins_valid && !pins_ready, pins_valid && $stable(pins_nibble) && $stable(pins_enable) && $stable(pins_hold_us), "stalled event changed")

endmodule

bind char_lcd_nibble_write_sequencer_top lcd4_checker #(
    .PULSE_WAIT_US (PULSE_WAIT_US)
) u_lcd4_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_operation   (req.operation),
    .pins_valid      (pins.valid),
    .pins_ready      (pins.ready),
    .pins_nibble     (pins.nibble),
    .pins_read_write (pins.read_write),
    .pins_enable     (pins.enable),
    .pins_hold_us    (pins.hold_us)
);
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the 4-bit character LCD write sequencer: random stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import lcd4_pkg::*;

    localparam int PULSE_US     = 3000;
    localparam int RANDOM_OPS   = 125;
    localparam int QUIET_TAIL   = 25;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 40;
    localparam int TIMEOUT_NS   = 1000000;

    // Row base addresses of the display RAM and the power-up command string
    localparam logic [VALUE_W-1:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};
    localparam logic [VALUE_W-1:0] POWERUP_CMDS [6] =
        '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01, 8'h06};

    // Operation codes the block takes and drops
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [OP_W-1:0] OP_SPARES [3] = '{OP_SPARE_5, OP_SPARE_6, OP_SPARE_7};

    localparam logic [HOLD_W-1:0] HOLD_ZERO  = '0;
    localparam logic [HOLD_W-1:0] HOLD_PULSE = HOLD_W'(PULSE_US);
    localparam logic              RS_INSTR   = 1'b0;
    localparam logic              RS_DATA    = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] value;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
    } lcd_op_t;

    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic              read_write;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } pin_evt_t;

    logic clk;
    logic rst_n;

    lcd4_req_if req_ch ();
    lcd4_pin_if pin_ch ();

    char_lcd_nibble_write_sequencer_top #(
        .PULSE_WAIT_US(PULSE_US)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .pins  (pin_ch.source)
    );

    lcd_op_t  op_pending_q [$];
    pin_evt_t pin_expect_q [$];

    // Predictor copy of the last driven pins
    logic [NIB_W-1:0] shadow_nibble;
    logic             shadow_select;

    logic quiet_tail;
    int   req_gap;
    int   pin_stall;
    int   ops_planned;
    int   mismatch_cnt;
    int   events_seen;
    int   byte_ops, cursor_ops, clear_ops, init_ops, spare_ops;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < PRINT_CAP)
        begin
            $display("[%0t] error: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    task automatic check_pin(string field, int unsigned got, int unsigned want);
        if (got != want)
        begin
            report_mismatch($sformatf("pin event %0d: %s is 0x%0h, predicted 0x%0h",
                                      events_seen, field, got, want));
        end
    endtask

    // Push one pin state and track it as the held one
    function automatic void push_pin_state(logic [NIB_W-1:0] nib, logic rs, logic en,
                                           logic [HOLD_W-1:0] hold);
        pin_evt_t e;
        e.nibble     = nib;
        e.reg_select = rs;
        e.read_write = RW_WRITE;
        e.enable     = en;
        e.hold_us    = hold;
        e.last       = 1'b0;
        pin_expect_q.push_back(e);
        shadow_nibble = nib;
        shadow_select = rs;
    endfunction

    // Six pin states per byte: set up, strobe, release for each nibble
    function automatic void push_byte_states(logic [VALUE_W-1:0] b, logic rs,
                                             logic [HOLD_W-1:0] gap);
        push_pin_state(b[7:4], rs, 1'b0, HOLD_ZERO);
        push_pin_state(b[7:4], rs, 1'b1, HOLD_PULSE);
        push_pin_state(b[7:4], rs, 1'b0, HOLD_PULSE);
        push_pin_state(b[3:0], rs, 1'b0, HOLD_ZERO);
        push_pin_state(b[3:0], rs, 1'b1, HOLD_PULSE);
        push_pin_state(b[3:0], rs, 1'b0, gap);
    endfunction

    function automatic void predict_pin_events(lcd_op_t item);
        int                 first;
        int                 i;
        logic [VALUE_W-1:0] addr;
        first = pin_expect_q.size();
        case (item.operation)
            OP_CMD:
            begin
                push_byte_states(item.value, RS_INSTR, HOLD_ZERO);
                byte_ops++;
            end
            OP_DATA:
            begin
                push_byte_states(item.value, RS_DATA, HOLD_ZERO);
                byte_ops++;
            end
            OP_CURSOR:
            begin
                addr = ROW_ADDR[item.row] + {2'b00, item.column};
                push_byte_states(addr, RS_INSTR, HOLD_PULSE);
                cursor_ops++;
            end
            OP_INIT:
            begin
                push_pin_state(shadow_nibble, shadow_select, 1'b0, INIT_GAP_US);
                for (i = 0; i < 6; i++)
                begin
                    push_byte_states(POWERUP_CMDS[i], RS_INSTR, INIT_GAP_US);
                end
                init_ops++;
            end
            OP_CLEAR:
            begin
                push_byte_states(CMD_CLEAR, RS_INSTR, HOLD_PULSE);
                clear_ops++;
            end
            default:
            begin
                spare_ops++;
            end
        endcase
        // Flag the final event of this operation
        if (pin_expect_q.size() > first)
        begin
            pin_expect_q[pin_expect_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                                     logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        lcd_op_t item;
        item.operation = op;
        item.value     = val;
        item.column    = col;
        item.row       = row;
        op_pending_q.push_back(item);
        if (op <= OP_CLEAR)
        begin
            ops_planned++;
        end
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        if ($urandom_range(0, 7) == 0)
        begin
            return COL_W'($urandom_range(40, 63));
        end
        return COL_W'($urandom_range(0, 39));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        return VALUE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        return ROW_W'($urandom_range(0, 3));
    endfunction

    // Request driver: hold a beat until taken, idle in random bursts
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        lcd_op_t nxt;
        logic    drive;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= '0;
            req_ch.value     <= '0;
            req_ch.column    <= '0;
            req_ch.row       <= '0;
            quiet_tail       <= 1'b0;
            req_gap = 0;
        end
        else
        begin
            drive = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.operation = req_ch.operation;
                nxt.value     = req_ch.value;
                nxt.column    = req_ch.column;
                nxt.row       = req_ch.row;
                predict_pin_events(nxt);
                drive = 1'b0;
            end
            if (!drive)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                end
                else if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    req_gap = $urandom_range(1, 18) - 1;
                end
                else if (op_pending_q.size() != 0)
                begin
                    nxt = op_pending_q.pop_front();
                    req_ch.operation <= nxt.operation;
                    req_ch.value     <= nxt.value;
                    req_ch.column    <= nxt.column;
                    req_ch.row       <= nxt.row;
                    drive = 1'b1;
                end
            end
            req_ch.valid <= drive;
            quiet_tail   <= (op_pending_q.size() < QUIET_TAIL);
        end
    end

    // Pin monitor: stall in random bursts, check each beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : pin_monitor
        pin_evt_t want;
        logic     take;
        if (!rst_n)
        begin
            pin_ch.ready <= 1'b0;
            pin_stall = 0;
        end
        else
        begin
            if (pin_ch.valid && pin_ch.ready)
            begin
                if (pin_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("pin event %0d arrived with none predicted",
                                              events_seen));
                end
                else
                begin
                    want = pin_expect_q.pop_front();
                    check_pin("nibble", pin_ch.nibble, want.nibble);
                    check_pin("reg_select", pin_ch.reg_select, want.reg_select);
                    check_pin("read_write", pin_ch.read_write, want.read_write);
                    check_pin("enable", pin_ch.enable, want.enable);
                    check_pin("hold_us", pin_ch.hold_us, want.hold_us);
                    check_pin("last", pin_ch.last, want.last);
                end
                events_seen++;
            end
            if (pin_stall > 0)
            begin
                pin_stall--;
                take = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                pin_stall = $urandom_range(1, 18) - 1;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
            end
            pin_ch.ready <= take;
        end
    end

    initial
    begin : stimulus
        int target;
        int k;
        int line_len;
        int pick;
        logic [VALUE_W-1:0] ch;

        shadow_nibble = '0;
        shadow_select = 1'b0;
        ops_planned   = 0;
        mismatch_cnt  = 0;
        events_seen   = 0;
        byte_ops      = 0;
        cursor_ops    = 0;
        clear_ops     = 0;
        init_ops      = 0;
        spare_ops     = 0;

        // Directed: init from reset state, byte extremes, cursor corners and wraps,
        // dropped codes, init after data leaves rs high
        queue_op(OP_INIT, 8'h00, 6'd0, 2'd0);
        queue_op(OP_CMD, 8'h00, 6'd0, 2'd0);
        queue_op(OP_CMD, 8'hFF, 6'd63, 2'd3);
        queue_op(OP_DATA, 8'hA5, 6'd21, 2'd1);
        queue_op(OP_DATA, 8'h5A, 6'd42, 2'd2);
        queue_op(OP_DATA, 8'hFF, 6'd0, 2'd0);
        queue_op(OP_SPARE_5, 8'hFF, 6'd63, 2'd3);
        queue_op(OP_INIT, 8'hFF, 6'd63, 2'd3);
        queue_op(OP_CLEAR, 8'h00, 6'd0, 2'd0);
        queue_op(OP_CURSOR, 8'h00, 6'd0, 2'd0);
        queue_op(OP_CURSOR, 8'hFF, 6'd39, 2'd1);
        queue_op(OP_CURSOR, 8'h55, 6'd20, 2'd2);
        queue_op(OP_CURSOR, 8'hAA, 6'd39, 2'd3);
        queue_op(OP_CURSOR, 8'h00, 6'd63, 2'd3);
        queue_op(OP_CURSOR, 8'h00, 6'd63, 2'd1);
        queue_op(OP_CURSOR, 8'h00, 6'd44, 2'd3);
        queue_op(OP_SPARE_6, 8'h00, 6'd0, 2'd0);
        queue_op(OP_DATA, 8'h00, 6'd0, 2'd0);
        queue_op(OP_SPARE_7, 8'h3C, 6'd17, 2'd2);
        queue_op(OP_INIT, 8'h00, 6'd0, 2'd0);
        queue_op(OP_CLEAR, 8'hFF, 6'd63, 2'd3);
        queue_op(OP_DATA, 8'h3C, 6'd5, 2'd2);

        // Random: mostly cursor moves followed by a run of characters
        target = ops_planned + RANDOM_OPS;
        while (ops_planned < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
            begin
                queue_op(OP_CURSOR, pick_value(), pick_column(), pick_row());
                line_len = $urandom_range(1, 8);
                for (k = 0; k < line_len; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        ch = pick_value();
                    end
                    else
                    begin
                        ch = VALUE_W'($urandom_range(8'h20, 8'h7E));
                    end
                    queue_op(OP_DATA, ch, pick_column(), pick_row());
                end
            end
            else if (pick < 13)
            begin
                queue_op(OP_CMD, pick_value(), pick_column(), pick_row());
            end
            else if (pick < 15)
            begin
                queue_op(OP_DATA, pick_value(), pick_column(), pick_row());
            end
            else if (pick == 15)
            begin
                queue_op(OP_CLEAR, pick_value(), pick_column(), pick_row());
            end
            else if (pick == 16)
            begin
                queue_op(OP_INIT, pick_value(), pick_column(), pick_row());
            end
            else if (pick == 17)
            begin
                queue_op(OP_SPARES[$urandom_range(0, 2)], pick_value(), pick_column(),
                         pick_row());
            end
            else
            begin
                queue_op(OP_CURSOR, pick_value(), COL_W'($urandom_range(0, 63)), pick_row());
            end
        end

        // Assert reset once the driver and monitor are waiting on it
        rst_n = 1'b1;
        #0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken, every predicted event seen
        while (op_pending_q.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (pin_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d byte writes, %0d cursor moves, %0d clears, %0d inits, %0d dropped codes",
                 byte_ops, cursor_ops, clear_ops, init_ops, spare_ops);
        $display("Checked %0d pin events, %0d field errors", events_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d requests and %0d pin events outstanding",
                 op_pending_q.size(), pin_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
